>>> rtl/mwms_pkg.sv
package mwms_pkg;

	localparam int WHEEL_COUNT = 4;
	localparam int WHEEL_IDX_W = 2;
	localparam int SPEED_W     = 16;
	localparam int GAIN_W      = 16;
	localparam int LIMIT_W     = 15;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 16;

	// mixed speeds before scaling stay well below 2^20 in magnitude
	localparam int MIX_W  = 22;
	localparam int MAG_W  = 21;
	localparam int PROD_W = MIX_W + GAIN_W + 1;

	// scaled magnitude never exceeds the speed limit, so 16 quotient bits do
	localparam int QUO_W     = 16;
	localparam int DIV_STEPS = QUO_W;
	localparam int CNT_W     = 4;

	localparam int FRAC_BITS = 12;
	localparam logic signed [PROD_W-1:0] ROUND_HALF = PROD_W'(2048);

	localparam logic [GAIN_W-1:0]  GAIN_RESET = GAIN_W'(4096);
	localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(4096);
	localparam logic [LIMIT_W-1:0] BAND_RESET = LIMIT_W'(41);
	localparam logic [LIMIT_W-1:0] STEP_RESET = LIMIT_W'(41);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ROTATION_GAIN = 2'd0,
		REG_SPEED_LIMIT   = 2'd1,
		REG_DEAD_BAND     = 2'd2,
		REG_STEP_LIMIT    = 2'd3
	} reg_index_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ROT,
		ST_MIX,
		ST_MAX,
		ST_MUL,
		ST_DIV,
		ST_SLEW,
		ST_FIN
	} state_t;

	typedef struct packed {
		logic [MIX_W-1:0] rem;
		logic             q_bit;
	} div_step_t;

endpackage

>>> rtl/mwms_if.sv
interface mwms_cmd_if;
	logic                                valid;
	logic                                ready;
	logic signed [mwms_pkg::SPEED_W-1:0] forward_speed;
	logic signed [mwms_pkg::SPEED_W-1:0] side_speed;
	logic signed [mwms_pkg::SPEED_W-1:0] turn_speed;

	modport source (output valid, output forward_speed, output side_speed,
		output turn_speed, input ready);
	modport sink (input valid, input forward_speed, input side_speed,
		input turn_speed, output ready);
endinterface

interface mwms_wheel_if;
	logic                                valid;
	logic                                ready;
	logic signed [mwms_pkg::SPEED_W-1:0] wheel0_target;
	logic signed [mwms_pkg::SPEED_W-1:0] wheel1_target;
	logic signed [mwms_pkg::SPEED_W-1:0] wheel2_target;
	logic signed [mwms_pkg::SPEED_W-1:0] wheel3_target;

	modport source (output valid, output wheel0_target, output wheel1_target,
		output wheel2_target, output wheel3_target, input ready);
	modport sink (input valid, input wheel0_target, input wheel1_target,
		input wheel2_target, input wheel3_target, output ready);
endinterface

>>> rtl/mwms_alu.sv
module mwms_alu (
	input  logic signed [mwms_pkg::MIX_W-1:0]  mul_a,
	input  logic [mwms_pkg::GAIN_W-1:0]        mul_b,
	output logic signed [mwms_pkg::PROD_W-1:0] product,
	input  logic [mwms_pkg::MIX_W-1:0]         rem,
	input  logic                               num_bit,
	input  logic [mwms_pkg::MAG_W-1:0]         divisor,
	output mwms_pkg::div_step_t                step
);
	import mwms_pkg::*;

	logic signed [GAIN_W:0] mul_b_s;
	logic [MIX_W-1:0]       trial;
	logic [MIX_W-1:0]       div_ext;
	logic                   ge;

	assign mul_b_s = $signed({1'b0, mul_b});
	assign product = PROD_W'(mul_a) * PROD_W'(mul_b_s);

	// one restoring step: shift in the next numerator bit, subtract if it fits
	assign trial   = {rem[MIX_W-2:0], num_bit};
	assign div_ext = {1'b0, divisor};
	assign ge      = trial >= div_ext;

	always_comb begin
		step.q_bit = ge;
		step.rem   = ge ? (trial - div_ext) : trial;
	end

endmodule

>>> rtl/mecanum_wheel_mix_slew_core.sv
// Mecanum wheel mixer: each command item (vx, vy, vz in signed Q3.12) yields one
// result item of four wheel targets. The rotation term gain*vz is rounded half
// up to Q3.12 and mixed as vx+vy-w, vx+vy+w, vx-vy+w, vx-vy-w. When the largest
// magnitude exceeds speed_limit all four are scaled by speed_limit/largest,
// truncated toward zero; then each target snaps to zero inside the dead band or
// slews toward its speed by at most step_limit, saturated to 16 bits. One item
// is worked on at a time through a single shared multiplier and a one-bit-per-
// cycle divider, one 16-step division per wheel when scaling is needed; ready
// returns as the result is loaded into the output register, which holds it
// until taken. The user must write the registers only while idle; the block
// itself does not enforce it. Targets clear on reset.
module mecanum_wheel_mix_slew_core (
	input  logic                           clk,
	input  logic                           arst_n,
	mwms_cmd_if.sink                       cmd,
	mwms_wheel_if.source                   wheels,
	input  logic                           cfg_we,
	input  logic [mwms_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [mwms_pkg::CFG_DATA_W-1:0] cfg_data
);
	import mwms_pkg::*;

	state_t state_q, state_d;

	logic [GAIN_W-1:0]  gain_q;
	logic [LIMIT_W-1:0] lim_q;
	logic [LIMIT_W-1:0] band_q;
	logic [LIMIT_W-1:0] stp_q;

	logic signed [SPEED_W-1:0] vx_q, vy_q, vz_q;
	logic signed [MIX_W-1:0]   w_q;
	logic signed [MIX_W-1:0]   s_q [WHEEL_COUNT];
	logic [MAG_W-1:0]          m_q;
	logic                      scale_q;
	logic [WHEEL_IDX_W-1:0]    idx_q;
	logic [CNT_W-1:0]          cnt_q;
	logic [MIX_W-1:0]          rem_q;
	logic [QUO_W-1:0]          num_q;
	logic signed [SPEED_W-1:0] tgt_q [WHEEL_COUNT];
	logic signed [SPEED_W-1:0] out_q [WHEEL_COUNT];
	logic                      out_valid_q;

	logic signed [MIX_W-1:0]  sel_s;
	logic [MIX_W-1:0]         sel_mag;
	logic signed [MIX_W-1:0]  mul_a;
	logic [GAIN_W-1:0]        mul_b;
	logic signed [PROD_W-1:0] product;
	logic signed [PROD_W-1:0] rounded;
	div_step_t                step;
	logic [MAG_W-1:0]         mag [WHEEL_COUNT];
	logic [MAG_W-1:0]         mag_max;
	logic signed [MIX_W-1:0]  quo_s;
	logic signed [MIX_W-1:0]  speed;
	logic [MIX_W-1:0]         speed_mag;
	logic signed [MIX_W-1:0]  stp_s;
	logic signed [MIX_W-1:0]  delta;
	logic signed [MIX_W-1:0]  delta_c;
	logic signed [MIX_W-1:0]  sum;
	logic signed [SPEED_W-1:0] slew_val;
	logic                     in_band;
	logic                     accept;
	logic                     out_load;
	logic                     last_wheel;

	assign accept     = cmd.valid && cmd.ready;
	assign cmd.ready  = (state_q == ST_IDLE);
	assign out_load   = (state_q == ST_FIN) && (!out_valid_q || wheels.ready);
	assign last_wheel = (idx_q == WHEEL_IDX_W'(WHEEL_COUNT - 1));

	// shared multiplier: gain*vz first, then |s|*limit for each wheel
	assign sel_s   = s_q[idx_q];
	assign sel_mag = sel_s[MIX_W-1] ? MIX_W'(-sel_s) : MIX_W'(sel_s);
	assign mul_a   = (state_q == ST_ROT) ? MIX_W'(vz_q) : $signed(sel_mag);
	assign mul_b   = (state_q == ST_ROT) ? gain_q : GAIN_W'(lim_q);

	mwms_alu u_alu (
		.mul_a   (mul_a),
		.mul_b   (mul_b),
		.product (product),
		.rem     (rem_q),
		.num_bit (num_q[QUO_W-1]),
		.divisor (m_q),
		.step    (step)
	);

	assign rounded = (product + ROUND_HALF) >>> FRAC_BITS;

	always_comb begin
		for (int i = 0; i < WHEEL_COUNT; i++) begin
			mag[i] = s_q[i][MIX_W-1] ? MAG_W'(-s_q[i]) : MAG_W'(s_q[i]);
		end
		mag_max = mag[0];
		for (int i = 1; i < WHEEL_COUNT; i++) begin
			if (mag[i] > mag_max) begin
				mag_max = mag[i];
			end
		end
	end

	// slew of the selected wheel
	always_comb begin
		quo_s     = $signed(MIX_W'(num_q));
		speed     = scale_q ? (sel_s[MIX_W-1] ? -quo_s : quo_s) : sel_s;
		speed_mag = speed[MIX_W-1] ? MIX_W'(-speed) : MIX_W'(speed);
		in_band   = speed_mag < MIX_W'(band_q);
		stp_s     = $signed(MIX_W'(stp_q));
		delta     = speed - MIX_W'(tgt_q[idx_q]);
		if (delta > stp_s) begin
			delta_c = stp_s;
		end else if (delta < -stp_s) begin
			delta_c = -stp_s;
		end else begin
			delta_c = delta;
		end
		sum = MIX_W'(tgt_q[idx_q]) + delta_c;
		if (sum > MIX_W'(32767)) begin
			slew_val = SPEED_W'(32767);
		end else if (sum < -MIX_W'(32768)) begin
			slew_val = SPEED_W'(-32768);
		end else begin
			slew_val = SPEED_W'(sum);
		end
		if (in_band) begin
			slew_val = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: if (accept) state_d = ST_ROT;
			ST_ROT:  state_d = ST_MIX;
			ST_MIX:  state_d = ST_MAX;
			ST_MAX:  state_d = (mag_max > MAG_W'(lim_q)) ? ST_MUL : ST_SLEW;
			ST_MUL:  state_d = ST_DIV;
			ST_DIV:  if (cnt_q == CNT_W'(DIV_STEPS - 1)) state_d = ST_SLEW;
			ST_SLEW: begin
				if (last_wheel) begin
					state_d = ST_FIN;
				end else begin
					state_d = scale_q ? ST_MUL : ST_SLEW;
				end
			end
			ST_FIN:  if (out_load) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q <= GAIN_RESET;
			lim_q  <= LIMIT_RESET;
			band_q <= BAND_RESET;
			stp_q  <= STEP_RESET;
		end else if (cfg_we) begin
			case (reg_index_t'(cfg_index))
				REG_ROTATION_GAIN: gain_q <= cfg_data[GAIN_W-1:0];
				REG_SPEED_LIMIT:   lim_q  <= cfg_data[LIMIT_W-1:0];
				REG_DEAD_BAND:     band_q <= cfg_data[LIMIT_W-1:0];
				REG_STEP_LIMIT:    stp_q  <= cfg_data[LIMIT_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q   <= '0;
			cnt_q   <= '0;
			scale_q <= 1'b0;
			for (int i = 0; i < WHEEL_COUNT; i++) begin
				tgt_q[i] <= '0;
			end
		end else begin
			case (state_q)
				ST_MAX: begin
					scale_q <= mag_max > MAG_W'(lim_q);
					idx_q   <= '0;
				end
				ST_MUL:  cnt_q <= '0;
				ST_DIV:  cnt_q <= cnt_q + CNT_W'(1);
				ST_SLEW: begin
					tgt_q[idx_q] <= slew_val;
					idx_q        <= idx_q + WHEEL_IDX_W'(1);
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					vx_q <= cmd.forward_speed;
					vy_q <= cmd.side_speed;
					vz_q <= cmd.turn_speed;
				end
			end
			ST_ROT: w_q <= MIX_W'(rounded);
			ST_MIX: begin
				s_q[0] <= MIX_W'(vx_q) + MIX_W'(vy_q) - w_q;
				s_q[1] <= MIX_W'(vx_q) + MIX_W'(vy_q) + w_q;
				s_q[2] <= MIX_W'(vx_q) - MIX_W'(vy_q) + w_q;
				s_q[3] <= MIX_W'(vx_q) - MIX_W'(vy_q) - w_q;
			end
			ST_MAX: m_q <= mag_max;
			ST_MUL: begin
				// |s|*limit < m*2^16, so the upper part already sits below the divisor
				rem_q <= product[QUO_W+MIX_W-1:QUO_W];
				num_q <= product[QUO_W-1:0];
			end
			ST_DIV: begin
				rem_q <= step.rem;
				num_q <= {num_q[QUO_W-2:0], step.q_bit};
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (wheels.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			for (int i = 0; i < WHEEL_COUNT; i++) begin
				out_q[i] <= tgt_q[i];
			end
		end
	end

	assign wheels.valid         = out_valid_q;
	assign wheels.wheel0_target = out_q[0];
	assign wheels.wheel1_target = out_q[1];
	assign wheels.wheel2_target = out_q[2];
	assign wheels.wheel3_target = out_q[3];

endmodule

>>> rtl/mwms_checker.sv
module mwms_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [63:0] out_data
);

	// a pending result item holds until taken
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result item dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(out_data))
		else $error("result item changed while stalled");

	// one item at a time
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("second item taken while busy");

	// a result never appears right after an accept
	a_no_early_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !$rose(out_valid))
		else $error("result item appeared too early");

endmodule

bind mecanum_wheel_mix_slew_core mwms_checker u_mwms_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (cmd.valid),
	.in_ready  (cmd.ready),
	.out_valid (wheels.valid),
	.out_ready (wheels.ready),
	.out_data  ({wheels.wheel0_target, wheels.wheel1_target,
		wheels.wheel2_target, wheels.wheel3_target})
);

>>> tb/tb_mecanum_wheel_mix_slew_core.sv
module tb_mecanum_wheel_mix_slew_core;
	timeunit 1ns;
	timeprecision 1ps;

	import mwms_pkg::*;

	localparam int CYCLE_LIMIT  = 600000;
	localparam int RANDOM_ITEMS = 800;

	typedef logic signed [SPEED_W-1:0] speed_t;
	typedef logic [WHEEL_COUNT-1:0][SPEED_W-1:0] wheel_set_t;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	mwms_cmd_if cmd_bus();
	mwms_wheel_if wheel_bus();

	mecanum_wheel_mix_slew_core dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd_bus),
		.wheels   (wheel_bus),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	// predictor state and its copy of the registers
	logic [GAIN_W-1:0]  gain_reg;
	logic [LIMIT_W-1:0] limit_reg;
	logic [LIMIT_W-1:0] band_reg;
	logic [LIMIT_W-1:0] step_reg;
	speed_t             model_targets [WHEEL_COUNT];

	wheel_set_t expected_targets [$];
	int commands_sent;
	int results_seen;
	int settings_used;
	int fail_count;
	int cycle_count;
	int burst_left;
	int stall_mode;
	int mode_left;

	always #6 clk = ~clk;

	function automatic longint mag(input longint v);
		return (v < 0) ? -v : v;
	endfunction

	function automatic wheel_set_t mix_and_slew(input speed_t vx, input speed_t vy,
		input speed_t vz);
		longint w;
		longint m;
		longint d;
		longint t;
		longint s [WHEEL_COUNT];
		wheel_set_t res;
		// round half up from q.24 to q3.12
		w = (longint'(gain_reg) * longint'(vz) + 2048) >>> FRAC_BITS;
		s[0] = longint'(vx) + longint'(vy) - w;
		s[1] = longint'(vx) + longint'(vy) + w;
		s[2] = longint'(vx) - longint'(vy) + w;
		s[3] = longint'(vx) - longint'(vy) - w;
		m = 0;
		for (int i = 0; i < WHEEL_COUNT; i++) begin
			if (mag(s[i]) > m)
				m = mag(s[i]);
		end
		if (m > longint'(limit_reg)) begin
			for (int i = 0; i < WHEEL_COUNT; i++)
				s[i] = (s[i] * longint'(limit_reg)) / m;
		end
		for (int i = 0; i < WHEEL_COUNT; i++) begin
			if (mag(s[i]) < longint'(band_reg)) begin
				model_targets[i] = '0;
			end else begin
				d = s[i] - longint'(model_targets[i]);
				if (d > longint'(step_reg))
					d = longint'(step_reg);
				else if (d < -longint'(step_reg))
					d = -longint'(step_reg);
				t = longint'(model_targets[i]) + d;
				if (t > 32767)
					t = 32767;
				else if (t < -32768)
					t = -32768;
				model_targets[i] = speed_t'(t);
			end
			res[i] = model_targets[i];
		end
		return res;
	endfunction

	function automatic speed_t rand_speed();
		case ($urandom_range(0, 5))
			0: return speed_t'(-32768);
			1: return speed_t'(32767);
			2: return speed_t'(int'($urandom_range(0, 600)) - 300);
			default: return speed_t'($urandom);
		endcase
	endfunction

	function automatic speed_t nudge(input speed_t v, input int amt);
		longint t;
		t = longint'(v) + longint'($urandom_range(0, 2 * amt)) - amt;
		if (t > 32767)
			t = 32767;
		else if (t < -32768)
			t = -32768;
		return speed_t'(t);
	endfunction

	function automatic logic [LIMIT_W-1:0] pick_q12();
		case ($urandom_range(0, 5))
			0: return '0;
			1: return LIMIT_W'(32767);
			2: return LIMIT_W'($urandom_range(0, 200));
			3: return LIMIT_W'($urandom_range(0, 4096));
			default: return LIMIT_W'($urandom);
		endcase
	endfunction

	function automatic logic [GAIN_W-1:0] pick_gain();
		case ($urandom_range(0, 4))
			0: return '0;
			1: return GAIN_W'(65535);
			2: return GAIN_W'(4096);
			default: return GAIN_W'($urandom);
		endcase
	endfunction

	task automatic send_command(input speed_t vx, input speed_t vy, input speed_t vz);
		cmd_bus.valid <= 1'b1;
		cmd_bus.forward_speed <= vx;
		cmd_bus.side_speed <= vy;
		cmd_bus.turn_speed <= vz;
		do @(posedge clk); while (!cmd_bus.ready);
		expected_targets.push_back(mix_and_slew(vx, vy, vz));
		commands_sent++;
	endtask

	task automatic idle_sender(input int cycles);
		cmd_bus.valid <= 1'b0;
		repeat (cycles) @(posedge clk);
	endtask

	// bursts of back-to-back items with random gaps between them
	task automatic pace_sender();
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			if ($urandom_range(0, 3) != 0)
				idle_sender(($urandom_range(0, 4) == 0) ? $urandom_range(1, 90)
					: $urandom_range(1, 10));
			burst_left = $urandom_range(1, 24);
		end
	endtask

	task automatic wait_drained();
		cmd_bus.valid <= 1'b0;
		while (expected_targets.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input reg_index_t idx, input logic [CFG_DATA_W-1:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
	endtask

	// only called while idle; bit 15 of the narrow registers is noise
	task automatic set_config(input logic [GAIN_W-1:0] gain, input logic [LIMIT_W-1:0] lim,
		input logic [LIMIT_W-1:0] band, input logic [LIMIT_W-1:0] stp);
		write_reg(REG_ROTATION_GAIN, gain);
		write_reg(REG_SPEED_LIMIT, {1'($urandom_range(0, 1)), lim});
		write_reg(REG_DEAD_BAND, {1'($urandom_range(0, 1)), band});
		write_reg(REG_STEP_LIMIT, {1'($urandom_range(0, 1)), stp});
		cfg_we <= 1'b0;
		gain_reg = gain;
		limit_reg = lim;
		band_reg = band;
		step_reg = stp;
		settings_used++;
	endtask

	task automatic test_reset_defaults();
		send_command(16'sd0, 16'sd0, 16'sd0);
		send_command(16'sd32767, 16'sd0, 16'sd0);
		send_command(-16'sd32768, 16'sd0, 16'sd0);
		send_command(16'sd0, 16'sd32767, 16'sd0);
		send_command(16'sd0, 16'sd0, -16'sd32768);
		send_command(16'sd32767, 16'sd32767, 16'sd32767);
		send_command(-16'sd32768, -16'sd32768, -16'sd32768);
		// below the band, targets snap back
		send_command(16'sd20, 16'sd0, 16'sd0);
		wait_drained();
	endtask

	task automatic test_gain_extremes();
		set_config(GAIN_W'(65535), LIMIT_W'(32767), '0, LIMIT_W'(32767));
		send_command(16'sd0, 16'sd0, 16'sd32767);
		send_command(16'sd0, 16'sd0, -16'sd32768);
		send_command(-16'sd32768, 16'sd32767, -16'sd32768);
		send_command(16'sd0, 16'sd0, 16'sd0);
		wait_drained();
		set_config('0, LIMIT_W'(32767), LIMIT_W'(41), LIMIT_W'(32767));
		send_command(16'sd32767, -16'sd32768, 16'sd32767);
		wait_drained();
	endtask

	task automatic test_zero_speed_limit();
		set_config(GAIN_W'(4096), '0, LIMIT_W'(41), LIMIT_W'(41));
		send_command(16'sd1, 16'sd0, 16'sd0);
		send_command(16'sd0, 16'sd0, 16'sd0);
		send_command(-16'sd32768, 16'sd0, 16'sd0);
		wait_drained();
	endtask

	task automatic test_zero_step_limit();
		set_config(GAIN_W'(4096), LIMIT_W'(32767), '0, LIMIT_W'(32767));
		send_command(16'sd5000, 16'sd1000, 16'sd0);
		wait_drained();
		set_config(GAIN_W'(4096), LIMIT_W'(32767), '0, '0);
		send_command(-16'sd8000, 16'sd3000, 16'sd100);
		send_command(16'sd0, 16'sd0, 16'sd0);
		wait_drained();
	endtask

	task automatic test_zero_dead_band();
		set_config(GAIN_W'(4096), LIMIT_W'(32767), '0, LIMIT_W'(100));
		send_command(16'sd3000, 16'sd0, 16'sd0);
		// a zero speed slews toward zero instead of snapping
		send_command(16'sd0, 16'sd0, 16'sd0);
		send_command(16'sd0, 16'sd0, 16'sd0);
		wait_drained();
		set_config(GAIN_W'(4096), LIMIT_W'(32767), LIMIT_W'(32767), LIMIT_W'(100));
		send_command(16'sd32767, 16'sd0, 16'sd0);
		wait_drained();
	endtask

	task automatic test_random_traffic(input int n_items);
		int sent;
		int phase;
		int phase_len;
		int run_len;
		int amt;
		speed_t bx;
		speed_t by;
		speed_t bz;
		sent = 0;
		phase = 0;
		while (sent < n_items) begin
			case (phase)
				0: set_config(GAIN_W'(65535), LIMIT_W'(32767), '0, LIMIT_W'(32767));
				1: set_config('0, LIMIT_W'(32767), LIMIT_W'(41), LIMIT_W'(200));
				2: set_config(GAIN_W'(4096), LIMIT_W'(4096), LIMIT_W'(41), LIMIT_W'(41));
				default: set_config(pick_gain(), pick_q12(), pick_q12(), pick_q12());
			endcase
			phase_len = $urandom_range(60, 120);
			burst_left = 0;
			for (int k = 0; k < phase_len && sent < n_items; ) begin
				if ($urandom_range(0, 3) != 0) begin
					// steady command with jitter so targets can settle
					bx = rand_speed();
					by = rand_speed();
					bz = rand_speed();
					run_len = $urandom_range(4, 40);
					amt = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 200);
					for (int r = 0; r < run_len; r++) begin
						send_command(nudge(bx, amt), nudge(by, amt), nudge(bz, amt));
						pace_sender();
					end
					k += run_len;
					sent += run_len;
				end else begin
					run_len = $urandom_range(1, 5);
					for (int r = 0; r < run_len; r++) begin
						send_command(speed_t'($urandom), speed_t'($urandom),
							speed_t'($urandom));
						pace_sender();
					end
					k += run_len;
					sent += run_len;
				end
				if ($urandom_range(0, 15) == 0)
					wait_drained();
			end
			wait_drained();
			phase++;
		end
	endtask

	// result sink: stall pattern plus field by field compare
	always @(posedge clk) begin : wheel_sink
		wheel_set_t want;
		wheel_set_t got;
		if (arst_n && wheel_bus.valid && wheel_bus.ready) begin
			got[0] = wheel_bus.wheel0_target;
			got[1] = wheel_bus.wheel1_target;
			got[2] = wheel_bus.wheel2_target;
			got[3] = wheel_bus.wheel3_target;
			results_seen++;
			if (expected_targets.size() == 0) begin
				$error("wheel result with no command item pending");
				fail_count++;
			end else begin
				want = expected_targets.pop_front();
				for (int i = 0; i < WHEEL_COUNT; i++) begin
					if (got[i] !== want[i]) begin
						$error("wheel%0d_target: expected %0d, actual %0d", i,
							$signed(want[i]), $signed(got[i]));
						fail_count++;
					end
				end
			end
		end
		if (mode_left == 0) begin
			stall_mode <= $urandom_range(0, 2);
			mode_left <= $urandom_range(32, 256);
		end else begin
			mode_left <= mode_left - 1;
		end
		case (stall_mode)
			0: wheel_bus.ready <= 1'b1;
			1: wheel_bus.ready <= 1'($urandom_range(0, 1));
			default: wheel_bus.ready <= ($urandom_range(0, 11) == 0);
		endcase
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("tb_mecanum_wheel_mix_slew_core NOT OK");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		cmd_bus.valid = 1'b0;
		cmd_bus.forward_speed = '0;
		cmd_bus.side_speed = '0;
		cmd_bus.turn_speed = '0;
		commands_sent = 0;
		results_seen = 0;
		settings_used = 0;
		fail_count = 0;
		burst_left = 0;
		gain_reg = GAIN_W'(4096);
		limit_reg = LIMIT_W'(4096);
		band_reg = LIMIT_W'(41);
		step_reg = LIMIT_W'(41);
		for (int i = 0; i < WHEEL_COUNT; i++)
			model_targets[i] = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_defaults();
		test_gain_extremes();
		test_zero_speed_limit();
		test_zero_step_limit();
		test_zero_dead_band();
		test_random_traffic(RANDOM_ITEMS);

		wait_drained();
		repeat (200) @(posedge clk);
		$display("sent %0d command items over %0d register settings, checked %0d wheel results",
			commands_sent, settings_used + 1, results_seen);
		$display("covered gain, limit, band and step extremes with steady and noisy commands");
		if (fail_count == 0) begin
			$display("tb_mecanum_wheel_mix_slew_core OK");
		end else begin
			$display("tb_mecanum_wheel_mix_slew_core NOT OK");
		end
		$finish;
	end

endmodule

>>> mecanum_wheel_mix_slew_core.f
rtl/mwms_pkg.sv
rtl/mwms_if.sv
rtl/mwms_alu.sv
rtl/mecanum_wheel_mix_slew_core.sv
rtl/mwms_checker.sv
tb/tb_mecanum_wheel_mix_slew_core.sv
